// ----- rtl/spf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// Shared widths, defaults and queue types of the sieve factoriser.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int VAL_W          = 12;
	localparam int TABLE_SIZE_DEF = 4096;
	localparam int QUEUE_DEPTH    = 2;
	localparam int MIN_PRIME      = 2;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             trivial;
	} spf_item_t;

	typedef struct packed {
		logic      valid;
		spf_item_t item;
	} spf_head_t;

endpackage

// ----- rtl/spf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_front
// Accepts input beats, flags values with no factors and queues them.
// ----------------------------------------------------------------------------
module spf_front #(
	parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [spf_pkg::VAL_W-1:0] value,
	input  logic                     fill_done,
	input  logic                     pop,
	output logic                     busy,
	output spf_pkg::spf_head_t       head
);

	localparam int QD  = spf_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	spf_pkg::spf_item_t buf_q [QD];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push, do_pop, trivial;

	assign busy    = ~fill_done | (cnt_q == QCW'(QD));
	assign push    = start & ~busy;
	assign do_pop  = pop & (cnt_q != '0);
	assign trivial = (value < spf_pkg::VAL_W'(spf_pkg::MIN_PRIME))
		| ({1'b0, value} >= (spf_pkg::VAL_W+1)'(DEPTH));

	assign head.valid = (cnt_q != '0);
	assign head.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].value   <= value;
			buf_q[wr_ptr_q].trivial <= trivial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/spf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spf_pkg::VAL_W-1:0] dividend,
	input  logic [spf_pkg::VAL_W-1:0] divisor,
	output logic                      done,
	output logic [spf_pkg::VAL_W-1:0] quotient
);

	localparam int W  = spf_pkg::VAL_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [W:0]    rem_sh, diff;

	assign rem_sh   = {rem_q, quo_q[W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/spf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_back
// Builds the smallest-prime-factor table, then factorises queued values.
// A zero entry marks a prime.
// ----------------------------------------------------------------------------
module spf_back #(
	parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spf_pkg::spf_head_t        head,
	output logic                      pop,
	output logic                      fill_done,
	output logic                      valid,
	output logic [spf_pkg::VAL_W-1:0] factor,
	output logic                      is_last,
	output logic                      no_factor
);

	localparam int W  = spf_pkg::VAL_W;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = AW + 1;

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_RD_I   = 4'd1;
	localparam logic [3:0] ST_CHK_I  = 4'd2;
	localparam logic [3:0] ST_RD_J   = 4'd3;
	localparam logic [3:0] ST_CHK_J  = 4'd4;
	localparam logic [3:0] ST_IDLE   = 4'd5;
	localparam logic [3:0] ST_LK_RD  = 4'd6;
	localparam logic [3:0] ST_LK_CHK = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;

	logic [W-1:0]  mem_q [DEPTH];
	logic [W-1:0]  rd_data_q;
	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [IW-1:0] i_q, j_q;
	logic [W-1:0]  x_q, p_q;
	logic          valid_q, last_q, none_q;
	logic [W-1:0]  factor_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [W-1:0]  wdata;
	logic          div_start, div_done;
	logic [W-1:0]  div_quo;

	spf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x_q),
		.divisor  (rd_data_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign fill_done = (state_q == ST_IDLE) || (state_q == ST_LK_RD)
		|| (state_q == ST_LK_CHK) || (state_q == ST_DIV);
	assign pop       = (state_q == ST_IDLE) & head.valid;
	assign div_start = (state_q == ST_LK_CHK) & (rd_data_q != '0);

	assign valid     = valid_q;
	assign factor    = factor_q;
	assign is_last   = last_q;
	assign no_factor = none_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		raddr = x_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
			end
			ST_RD_I: begin
				re    = (i_q < IW'(DEPTH));
				raddr = i_q[AW-1:0];
			end
			ST_RD_J: begin
				re    = (j_q < IW'(DEPTH));
				raddr = j_q[AW-1:0];
			end
			ST_CHK_J: begin
				we    = (rd_data_q == '0);
				waddr = j_q[AW-1:0];
				wdata = W'(i_q);
			end
			ST_LK_RD: begin
				re = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rd_data_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE)
			x_q <= head.item.value;
		else if ((state_q == ST_DIV) && div_done)
			x_q <= div_quo;
		if (state_q == ST_LK_CHK)
			p_q <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			i_q      <= IW'(spf_pkg::MIN_PRIME);
			j_q      <= '0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
			none_q   <= 1'b0;
			factor_q <= '0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= ST_RD_I;
				end
				ST_RD_I: begin
					state_q <= (i_q < IW'(DEPTH)) ? ST_CHK_I : ST_IDLE;
				end
				ST_CHK_I: begin
					if (rd_data_q == '0) begin
						j_q     <= i_q + i_q;
						state_q <= ST_RD_J;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RD_I;
					end
				end
				ST_RD_J: begin
					if (j_q < IW'(DEPTH)) begin
						state_q <= ST_CHK_J;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RD_I;
					end
				end
				ST_CHK_J: begin
					j_q     <= j_q + i_q;
					state_q <= ST_RD_J;
				end
				ST_IDLE: begin
					if (head.valid) begin
						if (head.item.trivial) begin
							valid_q  <= 1'b1;
							factor_q <= '0;
							last_q   <= 1'b1;
							none_q   <= 1'b1;
						end else begin
							state_q <= ST_LK_RD;
						end
					end
				end
				ST_LK_RD: begin
					state_q <= ST_LK_CHK;
				end
				ST_LK_CHK: begin
					if (rd_data_q == '0) begin
						// remaining value is prime
						valid_q  <= 1'b1;
						factor_q <= x_q;
						last_q   <= 1'b1;
						none_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						valid_q  <= 1'b1;
						factor_q <= p_q;
						last_q   <= (div_quo <= W'(1));
						none_q   <= 1'b0;
						state_q  <= (div_quo <= W'(1)) ? ST_IDLE : ST_LK_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/spf_sieve_factorizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_sieve_factorizer
// Smallest-prime-factor sieve and factoriser.
// ----------------------------------------------------------------------------
// After reset busy stays high while the table is cleared (one entry a cycle)
// and then sieved with a single-port read-modify-write sequence. A value is
// accepted when start is high and busy low; a two-beat queue lets new values
// in while an earlier one is still being factorised. Each prime factor comes
// out as one beat on valid, smallest first, with is_last on the final beat;
// 0, 1 and values beyond the table give one beat with no_factor set. Results
// are not held: the receiver must take each beat in the cycle valid is high.
// Every factor costs a table lookup plus a bit-serial division on the one
// shared divider, the final prime factor only the lookup.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer #(
	parameter int TABLE_SIZE = spf_pkg::TABLE_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [spf_pkg::VAL_W-1:0] value,
	output logic                      valid,
	output logic [spf_pkg::VAL_W-1:0] factor,
	output logic                      is_last,
	output logic                      no_factor
);

	localparam int DEPTH = (TABLE_SIZE < (1 << spf_pkg::VAL_W))
		? TABLE_SIZE : (1 << spf_pkg::VAL_W);

	spf_pkg::spf_head_t head;
	logic               pop, fill_done;

	spf_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.fill_done (fill_done),
		.pop       (pop),
		.busy      (busy),
		.head      (head)
	);

	spf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.fill_done (fill_done),
		.valid     (valid),
		.factor    (factor),
		.is_last   (is_last),
		.no_factor (no_factor)
	);

endmodule

// ----- tb/tb_spf_sieve_factorizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spf_sieve_factorizer
// Self-checking testbench for the smallest-prime-factor sieve factoriser.
// ----------------------------------------------------------------------------
// Builds its own smallest-prime-factor table and predicts, for every value
// accepted on start/busy, the factor beats in order. Each valid beat is
// checked field by field against the oldest prediction. Stimulus runs from
// directed corner values through random, smooth and prime values with
// random sender gaps, to a back-to-back stretch with no gaps at the end.
// ----------------------------------------------------------------------------
module tb_spf_sieve_factorizer;

	localparam int TBL_SIZE      = spf_pkg::TABLE_SIZE_DEF;
	localparam int MAX_BEATS     = 12;
	localparam int STALL_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 200;

	typedef struct {
		logic [spf_pkg::VAL_W-1:0] factor;
		logic                      is_last;
		logic                      no_factor;
	} factor_beat_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [spf_pkg::VAL_W-1:0] value;
	logic                      valid;
	logic [spf_pkg::VAL_W-1:0] factor;
	logic                      is_last;
	logic                      no_factor;

	int           spf_tab [TBL_SIZE];
	factor_beat_t pending_factors[$];
	int           errors;
	int           stall_cycles;
	bit           idle_en;

	spf_sieve_factorizer #(
		.TABLE_SIZE(TBL_SIZE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.valid    (valid),
		.factor   (factor),
		.is_last  (is_last),
		.no_factor(no_factor)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void predict_factors(input logic [spf_pkg::VAL_W-1:0] v);
		factor_beat_t b;
		int x;
		int p;
		int k;
		x = v;
		k = 0;
		if (x < spf_pkg::MIN_PRIME || x >= TBL_SIZE) begin
			b.factor    = '0;
			b.is_last   = 1'b1;
			b.no_factor = 1'b1;
			pending_factors = {pending_factors, b};
			return;
		end
		while (x > 1 && k < MAX_BEATS) begin
			p = spf_tab[x];
			if (p < spf_pkg::MIN_PRIME)
				p = x;
			x = x / p;
			b.factor    = p[spf_pkg::VAL_W-1:0];
			b.is_last   = (x <= 1 || k == MAX_BEATS - 1);
			b.no_factor = 1'b0;
			pending_factors = {pending_factors, b};
			k++;
		end
	endfunction

	// acceptance, result check and watchdog all sample pre-edge values
	always @(posedge clk) begin
		factor_beat_t exp_beat;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				predict_factors(value);
				moved = 1'b1;
			end
			if (valid) begin
				moved = 1'b1;
				if (pending_factors.size() == 0) begin
					$error("unexpected beat: factor=%0d is_last=%0b no_factor=%0b",
						factor, is_last, no_factor);
					errors++;
				end else begin
					exp_beat = pending_factors.pop_front();
					if (factor !== exp_beat.factor) begin
						$error("factor: expected %0d, actual %0d", exp_beat.factor, factor);
						errors++;
					end
					if (is_last !== exp_beat.is_last) begin
						$error("is_last: expected %0b, actual %0b", exp_beat.is_last, is_last);
						errors++;
					end
					if (no_factor !== exp_beat.no_factor) begin
						$error("no_factor: expected %0b, actual %0b",
							exp_beat.no_factor, no_factor);
						errors++;
					end
				end
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// start stays high after a beat unless a gap is taken
	task automatic send_value(input logic [spf_pkg::VAL_W-1:0] v);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			value <= spf_pkg::VAL_W'($urandom);
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	function automatic logic [spf_pkg::VAL_W-1:0] smooth_value();
		int small_primes[6] = '{2, 3, 5, 7, 11, 13};
		int v;
		int p;
		v = 1;
		for (int i = 0; i < MAX_BEATS; i++) begin
			p = small_primes[$urandom_range(0, 5)];
			if (v * p >= TBL_SIZE)
				break;
			v = v * p;
		end
		return v[spf_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [spf_pkg::VAL_W-1:0] prime_value();
		int v;
		v = 2;
		for (int i = 0; i < 1000; i++) begin
			v = $urandom_range(2, TBL_SIZE - 1);
			if (spf_tab[v] == v)
				break;
		end
		return v[spf_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [spf_pkg::VAL_W-1:0] mixed_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return spf_pkg::VAL_W'($urandom);
		else if (sel < 7)
			return smooth_value();
		else if (sel < 8)
			return spf_pkg::VAL_W'($urandom_range(0, 1));
		else
			return prime_value();
	endfunction

	task automatic test_corner_values();
		logic [spf_pkg::VAL_W-1:0] corners[$] = '{
			0, 1, 2, 3, 4, 9, 4095, 4094, 4093, 4091, 2048, 3072, 2187,
			2047, 3481, 4087, 4032, 1024, 30, 2310, 1, 0, 6, 12
		};
		idle_en = 1'b1;
		foreach (corners[i])
			send_value(corners[i]);
	endtask

	task automatic test_random_values();
		for (int i = 0; i < 200; i++) begin
			if (i % 25 == 0)
				idle_en = $urandom_range(0, 2) != 0;
			send_value(mixed_value());
		end
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int i = 0; i < 100; i++)
			send_value(mixed_value());
	endtask

	initial begin
		errors       = 0;
		stall_cycles = 0;
		idle_en      = 1'b0;
		for (int i = 0; i < TBL_SIZE; i++)
			spf_tab[i] = i;
		for (int i = 2; i < TBL_SIZE; i++)
			if (spf_tab[i] == i)
				for (int j = 2 * i; j < TBL_SIZE; j += i)
					if (spf_tab[j] == j)
						spf_tab[j] = i;

		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_random_values();
		test_back_to_back();
		start <= 1'b0;

		while (pending_factors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
